FILE: hdl/pll_cap_band_search_unit_macros.svh
// Assertion macros for the capacitor band search unit.
`ifndef PLL_CAP_BAND_SEARCH_UNIT_MACROS_SVH
`define PLL_CAP_BAND_SEARCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PCBS_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("pcbs check failed");

`define PCBS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("pcbs check failed");

`else

`define PCBS_ASSERT_SAME(label, clk, rst, a, b)

`define PCBS_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

FILE: hdl/pcbs_pkg.sv
package pcbs_pkg;

   localparam int COARSE_MAX_INDEX_DEF = 10;
   localparam int FINE_MAX_INDEX_DEF   = 6;

   localparam logic [3:0] COARSE_RESET_INDEX = 4'd10;
   localparam logic [2:0] FINE_RESET_INDEX   = 3'd6;
   localparam logic [3:0] FINEST_RESET_VALUE = 4'hf;
   localparam logic [3:0] FINEST_START_VALUE = 4'hf;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_MEASURE = 1'b1;

   localparam logic CSR_TARGET_COUNT  = 1'b0;
   localparam logic CSR_BYPASS_ENABLE = 1'b1;

   localparam logic [1:0] STAGE_CODE_COARSE   = 2'd0;
   localparam logic [1:0] STAGE_CODE_FINE     = 2'd1;
   localparam logic [1:0] STAGE_CODE_FINEST   = 2'd2;
   localparam logic [1:0] STAGE_CODE_FINISHED = 2'd3;

   typedef enum logic [3:0] {
      STG_COARSE   = 4'b0001,
      STG_FINE     = 4'b0010,
      STG_FINEST   = 4'b0100,
      STG_FINISHED = 4'b1000
   } stage_type;

   typedef struct packed {
      stage_type   stage;
      logic [3:0]  coarse_index;
      logic [2:0]  fine_index;
      logic [3:0]  finest_value;
   } srch_state_type;

   // packed so that coarse_code sits in the lowest bits
   typedef struct packed {
      logic        done_res;
      logic [1:0]  stage;
      logic [3:0]  finest_code;
      logic [5:0]  fine_code;
      logic [9:0]  coarse_code;
   } rsp_type;

   localparam int RSP_BITS   = $bits(rsp_type);
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   function automatic logic [9:0] thermo_coarse(input logic [3:0] idx);
      logic [9:0] t;
      for (int i = 0; i < 10; i++) begin
         t[i] = (4'(i) < idx);
      end
      return t;
   endfunction

   function automatic logic [5:0] thermo_fine(input logic [2:0] idx);
      logic [5:0] t;
      for (int i = 0; i < 6; i++) begin
         t[i] = (3'(i) < idx);
      end
      return t;
   endfunction

   function automatic logic [1:0] stage_code(input stage_type s);
      logic [1:0] c;
      case (s)
         STG_COARSE: begin
            c = STAGE_CODE_COARSE;
         end
         STG_FINE: begin
            c = STAGE_CODE_FINE;
         end
         STG_FINEST: begin
            c = STAGE_CODE_FINEST;
         end
         default: begin
            c = STAGE_CODE_FINISHED;
         end
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/pcbs_step.sv
module pcbs_step #(
   parameter int COARSE_MAX_INDEX = pcbs_pkg::COARSE_MAX_INDEX_DEF,
   parameter int FINE_MAX_INDEX   = pcbs_pkg::FINE_MAX_INDEX_DEF
) (
   input  pcbs_pkg::srch_state_type cur_state,
   input  logic                     op,
   input  logic [15:0]              measured_count,
   input  logic [15:0]              target_count,
   input  logic                     bypass_enable,
   output pcbs_pkg::srch_state_type nxt_state,
   output pcbs_pkg::rsp_type        rsp
);
   import pcbs_pkg::*;

   localparam logic [3:0] CMAX = 4'(COARSE_MAX_INDEX);
   localparam logic [2:0] FMAX = 3'(FINE_MAX_INDEX);

   logic cnt_eq;
   logic cnt_lt;

   assign cnt_eq = (measured_count == target_count);
   assign cnt_lt = (measured_count < target_count);

   always_comb begin
      nxt_state = cur_state;
      if (op == OP_START) begin
         if (bypass_enable) begin
            nxt_state.stage = STG_FINISHED;
         end else begin
            nxt_state.stage        = STG_COARSE;
            nxt_state.coarse_index = CMAX;
            nxt_state.fine_index   = FMAX;
            nxt_state.finest_value = FINEST_START_VALUE;
         end
      end else begin
         case (cur_state.stage)
            STG_COARSE: begin
               if (cnt_eq) begin
                  nxt_state.stage = STG_FINISHED;
               end else if (cnt_lt && (cur_state.coarse_index != 4'd0)) begin
                  nxt_state.coarse_index = cur_state.coarse_index - 4'd1;
               end else begin
                  if (!cnt_lt && (cur_state.coarse_index < CMAX)) begin
                     nxt_state.coarse_index = cur_state.coarse_index + 4'd1;
                  end
                  if (cur_state.fine_index != 3'd0) begin
                     nxt_state.fine_index = cur_state.fine_index - 3'd1;
                  end
                  nxt_state.stage = STG_FINE;
               end
            end
            STG_FINE: begin
               if (cnt_eq) begin
                  nxt_state.stage = STG_FINISHED;
               end else if (cnt_lt && (cur_state.fine_index != 3'd0)) begin
                  nxt_state.fine_index = cur_state.fine_index - 3'd1;
               end else begin
                  if (!cnt_lt && (cur_state.fine_index < FMAX)) begin
                     nxt_state.fine_index = cur_state.fine_index + 3'd1;
                  end
                  if (cur_state.finest_value != 4'd0) begin
                     nxt_state.finest_value = cur_state.finest_value - 4'd1;
                  end
                  nxt_state.stage = STG_FINEST;
               end
            end
            STG_FINEST: begin
               if (!cnt_lt || (cur_state.finest_value == 4'd0)) begin
                  nxt_state.stage = STG_FINISHED;
               end else begin
                  nxt_state.finest_value = cur_state.finest_value - 4'd1;
               end
            end
            default: begin
               nxt_state = cur_state;
            end
         endcase
      end
   end

   always_comb begin
      rsp.coarse_code = thermo_coarse(nxt_state.coarse_index);
      rsp.fine_code   = thermo_fine(nxt_state.fine_index);
      rsp.finest_code = nxt_state.finest_value;
      rsp.stage       = stage_code(nxt_state.stage);
      rsp.done_res    = (nxt_state.stage == STG_FINISHED);
   end

endmodule

FILE: hdl/pcbs_out_queue.sv
module pcbs_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pcbs_pkg::rsp_type push_data,
   output logic              not_full,
   output logic              out_valid,
   input  logic              out_ready,
   output pcbs_pkg::rsp_type out_data
);
   import pcbs_pkg::*;

   rsp_type    entry_ff [2];
   logic       wptr_ff;
   logic       wptr_in;
   logic       rptr_ff;
   logic       rptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign not_full  = !count_ff[1];
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/pll_cap_band_search_unit.sv
// Three-stage capacitor band search for an LC VCO. Every request transfer (tuser 0 start,
// tuser 1 one frequency count) yields exactly one response carrying the codes to apply next,
// the stage and a done flag. The step is a single compare and increment/decrement on the
// search registers, so one request is taken each cycle while req_tready is high, and its
// response is written into the output queue at the transfer; a two-entry output queue lets
// requests keep flowing while a response waits, and req_tready drops only while both entries
// are held. Write csr registers only while no response is pending.
`include "pll_cap_band_search_unit_macros.svh"

module pll_cap_band_search_unit #(
   parameter int COARSE_MAX_INDEX = pcbs_pkg::COARSE_MAX_INDEX_DEF,
   parameter int FINE_MAX_INDEX   = pcbs_pkg::FINE_MAX_INDEX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // measured_count
   input  logic                             req_tuser,  // op
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // coarse_code[9:0], fine_code[15:10], finest_code[19:16], stage[21:20],
   // done_res[22], zero[23]
   output logic [pcbs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [15:0]                      csr_wdata
);
   import pcbs_pkg::*;

   logic [15:0]    target_count_ff;
   logic           bypass_enable_ff;
   srch_state_type state_ff;
   srch_state_type state_in;
   rsp_type        step_rsp;
   rsp_type        q_data;
   logic           req_xfer;
   logic           idle_measure;
   logic           done_consistent;

   assign req_xfer = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff  <= 16'd0;
         bypass_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TARGET_COUNT: begin
               target_count_ff <= csr_wdata;
            end
            CSR_BYPASS_ENABLE: begin
               bypass_enable_ff <= csr_wdata[0];
            end
            default: begin
               target_count_ff <= target_count_ff;
            end
         endcase
      end
   end

   pcbs_step #(
      .COARSE_MAX_INDEX (COARSE_MAX_INDEX),
      .FINE_MAX_INDEX   (FINE_MAX_INDEX)
   ) u_step (
      .cur_state      (state_ff),
      .op             (req_tuser),
      .measured_count (req_tdata),
      .target_count   (target_count_ff),
      .bypass_enable  (bypass_enable_ff),
      .nxt_state      (state_in),
      .rsp            (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.stage        <= STG_FINISHED;
         state_ff.coarse_index <= COARSE_RESET_INDEX;
         state_ff.fine_index   <= FINE_RESET_INDEX;
         state_ff.finest_value <= FINEST_RESET_VALUE;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   pcbs_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (step_rsp),
      .not_full  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_data)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_BITS){1'b0}}, q_data};

   assign idle_measure    = req_xfer && (req_tuser == OP_MEASURE) &&
                            (state_ff.stage == STG_FINISHED);
   assign done_consistent = (q_data.done_res == (q_data.stage == STAGE_CODE_FINISHED));

   `PCBS_ASSERT_NEXT(a_xfer_gives_rsp, clock, reset, req_xfer, rsp_tvalid)
   `PCBS_ASSERT_SAME(a_stall_only_when_full, clock, reset, !req_tready, rsp_tvalid)
   `PCBS_ASSERT_NEXT(a_finished_holds, clock, reset, idle_measure, $stable(state_ff))
   `PCBS_ASSERT_SAME(a_done_matches_stage, clock, reset, rsp_tvalid, done_consistent)

endmodule
